FILE: rtl/elliptical_matte_blend_top_defines.svh
// assertion macros for the elliptical matte blend block
// expects i_clk and i_rst_n in the scope of each use
`ifndef ELLIPTICAL_MATTE_BLEND_TOP_DEFINES_SVH
`define ELLIPTICAL_MATTE_BLEND_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define EMB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("emb check failed");

// next-cycle implication, off during reset
`define EMB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("emb check failed");

`endif

FILE: rtl/emb_pkg.sv
// shared types, widths and constants of the elliptical matte blend block
// no dependencies
`default_nettype none

package emb_pkg;

    localparam int unsigned COORD_W     = 12;
    localparam int unsigned DIM_W       = 13;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned MAG_W       = 13;
    localparam int unsigned SQ_W        = 26;
    localparam int unsigned DEN_W       = 26;
    localparam int unsigned Q_W         = 24;
    localparam int unsigned P_W         = 48;
    localparam int unsigned A_W         = 17;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned RATIO_QB    = 24;
    localparam int unsigned ALPHA_QB    = 16;
    localparam int unsigned QDEPTH      = 4;
    localparam int unsigned MAX_DIM_DEF = 4096;

    localparam logic [Q_W-1:0]  Q_MAX    = 24'hFF_FFFF;
    localparam logic [Q_W-1:0]  Q_ONE    = 24'h01_0000;
    localparam logic [P_W-1:0]  P_BYPASS = 48'h0001_0000_0000;
    localparam logic [A_W-1:0]  A_ONE    = 17'h1_0000;
    localparam logic [CH_W-1:0] WHITE    = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_X      = 3'd0,
        CFG_FIRST_Y      = 3'd1,
        CFG_SECOND_X     = 3'd2,
        CFG_SECOND_Y     = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
    } t_cfg;

    // word handed from front end to back end
    typedef struct packed {
        logic [SQ_W-1:0] x2;
        logic [SQ_W-1:0] y2;
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic            zspan;
    } t_fitem;

    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic            zspan;
        logic            sat_dx;
        logic            sat_dy;
        logic            sat_ex;
        logic            sat_ey;
    } t_dside;

    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic            outside;
        logic [Q_W-1:0]  d;
        logic [Q_W-1:0]  e;
    } t_sum;

    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic            outside;
        logic [P_W-1:0]  p;
    } t_prod;

    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic            outside;
        logic            bypass;
    } t_aside;

    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic            outside;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/emb_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
// no package dependency; quotient must fit in QB bits
`default_nettype none

module emb_div_pipe #(
    parameter int unsigned NW = 42,
    parameter int unsigned DW = 26,
    parameter int unsigned QB = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QB-1:0] o_quo
);

    logic [DW-1:0] r_rem [QB];
    logic [DW-1:0] n_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [DW-1:0] n_den [QB];
    logic [QB-1:0] r_low [QB];
    logic [QB-1:0] n_low [QB];
    logic [QB-1:0] r_quo [QB];
    logic [QB-1:0] n_quo [QB];

    always_comb begin
        logic [DW-1:0] v_rem;
        logic [DW-1:0] v_den;
        logic [QB-1:0] v_low;
        logic [QB-1:0] v_quo;
        logic [DW:0]   v_t;
        for (int k = 0; k < QB; k++) begin
            if (k == 0) begin
                v_rem = DW'(i_num[NW-1:QB]);
                v_low = i_num[QB-1:0];
                v_quo = '0;
                v_den = i_den;
            end else begin
                v_rem = r_rem[(k == 0) ? 0 : k-1];
                v_low = r_low[(k == 0) ? 0 : k-1];
                v_quo = r_quo[(k == 0) ? 0 : k-1];
                v_den = r_den[(k == 0) ? 0 : k-1];
            end
            // shift in next dividend bit, subtract when it fits
            v_t = {v_rem, v_low[QB-1]};
            if (v_t >= {1'b0, v_den}) begin
                n_rem[k] = DW'(v_t - {1'b0, v_den});
                n_quo[k] = {v_quo[QB-2:0], 1'b1};
            end else begin
                n_rem[k] = DW'(v_t);
                n_quo[k] = {v_quo[QB-2:0], 1'b0};
            end
            n_low[k] = v_low << 1;
            n_den[k] = v_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

`default_nettype wire

FILE: rtl/emb_front.sv
// front end: input register, center offsets and their squares
// depends on emb_pkg
`default_nettype none

module emb_front
    import emb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire t_cfg               i_cfg,
    input  wire logic [COORD_W-1:0] i_row,
    input  wire logic [COORD_W-1:0] i_col,
    input  wire logic [CH_W-1:0]    i_ch0,
    input  wire logic [CH_W-1:0]    i_ch1,
    input  wire logic [CH_W-1:0]    i_ch2,
    input  wire logic               i_q_full,
    output logic                    o_valid,
    output t_fitem                  o_item
);

    logic               r_valid;
    logic [MAG_W-1:0]   r_mx;
    logic [MAG_W-1:0]   r_my;
    logic [CH_W-1:0]    r_ch0;
    logic [CH_W-1:0]    r_ch1;
    logic [CH_W-1:0]    r_ch2;
    logic               r_zspan;

    logic               accept;
    logic               hand;
    logic [MAG_W-1:0]   sum_x;
    logic [MAG_W-1:0]   sum_y;
    logic [MAG_W-1:0]   two_col;
    logic [MAG_W-1:0]   two_row;
    logic [MAG_W-1:0]   mx;
    logic [MAG_W-1:0]   my;

    assign o_full = r_valid && i_q_full;
    assign accept = i_push && !o_full;
    assign hand   = r_valid && !i_q_full;

    assign sum_x   = {1'b0, i_cfg.first_x} + {1'b0, i_cfg.second_x};
    assign sum_y   = {1'b0, i_cfg.first_y} + {1'b0, i_cfg.second_y};
    assign two_col = {i_col, 1'b0};
    assign two_row = {i_row, 1'b0};
    assign mx      = (two_col > sum_x) ? two_col - sum_x : sum_x - two_col;
    assign my      = (two_row > sum_y) ? two_row - sum_y : sum_y - two_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (hand) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mx    <= mx;
            r_my    <= my;
            r_ch0   <= i_ch0;
            r_ch1   <= i_ch1;
            r_ch2   <= i_ch2;
            r_zspan <= (i_cfg.first_x == i_cfg.second_x)
                    || (i_cfg.first_y == i_cfg.second_y);
        end
    end

    assign o_valid      = r_valid;
    assign o_item.x2    = SQ_W'(r_mx) * SQ_W'(r_mx);
    assign o_item.y2    = SQ_W'(r_my) * SQ_W'(r_my);
    assign o_item.ch0   = r_ch0;
    assign o_item.ch1   = r_ch1;
    assign o_item.ch2   = r_ch2;
    assign o_item.zspan = r_zspan;

endmodule

`default_nettype wire

FILE: rtl/emb_queue.sv
// short word queue between front end and back end
// depends on emb_pkg
`default_nettype none

module emb_queue
    import emb_pkg::*;
#(
    parameter int unsigned DEPTH = QDEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_fitem i_item,
    output logic        o_full,
    input  wire logic   i_rd,
    output logic        o_valid,
    output t_fitem      o_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_fitem          r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            wr;
    logic            rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr      = i_wr && !o_full;
    assign rd      = i_rd && o_valid;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/emb_back.sv
// back end: ratio dividers, falloff product, alpha divider, blend, result register
// depends on emb_pkg, emb_div_pipe and the assertion macro header
`default_nettype none
`include "elliptical_matte_blend_top_defines.svh"

module emb_back
    import emb_pkg::*;
#(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire logic          i_q_valid,
    input  wire t_fitem        i_q_item,
    output logic               o_q_rd,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [CH_W-1:0]    o_ch0,
    output logic [CH_W-1:0]    o_ch1,
    output logic [CH_W-1:0]    o_ch2,
    output logic               o_outside
);

    localparam logic [2*P_W:0] NUM_ONE = (2*P_W+1)'(1) << P_W;

    function automatic logic [CH_W-1:0] blend(input logic [A_W-1:0] a,
                                              input logic [CH_W-1:0] c);
        logic [25:0] v;
        v = 26'(a) * 26'(c) + 26'(A_ONE - a) * 26'(WHITE) + 26'(32768);
        return (v[25:16] > 10'(WHITE)) ? WHITE : v[23:16];
    endfunction

    logic                  en;
    logic [COORD_W-1:0]    sx;
    logic [COORD_W-1:0]    sy;
    logic [DIM_W-1:0]      w;
    logic [DIM_W-1:0]      h;
    logic [DEN_W-1:0]      r_sx2;
    logic [DEN_W-1:0]      r_sy2;
    logic [DEN_W-1:0]      r_w2;
    logic [DEN_W-1:0]      r_h2;

    logic                  r_b1_v;
    t_fitem                r_b1;
    t_dside                r_b1_sd;

    logic [RATIO_QB-1:0]   r_va;
    t_dside                r_sa [RATIO_QB];
    logic [Q_W-1:0]        q_dx;
    logic [Q_W-1:0]        q_dy;
    logic [Q_W-1:0]        q_ex;
    logic [Q_W-1:0]        q_ey;
    logic [Q_W-1:0]        rdx;
    logic [Q_W-1:0]        rdy;
    logic [Q_W-1:0]        rex;
    logic [Q_W-1:0]        rey;
    logic [Q_W:0]          dsum;
    logic [Q_W:0]          esum;
    logic [Q_W-1:0]        dval;
    logic [Q_W-1:0]        eval;

    logic                  r_b2_v;
    t_sum                  r_b2;
    logic                  r_b3_v;
    t_prod                 r_b3;

    logic [ALPHA_QB-1:0]   r_vb;
    t_aside                r_sb [ALPHA_QB];
    logic [ALPHA_QB-1:0]   q_a;
    logic [A_W-1:0]        alpha;
    t_aside                last_a;

    logic                  r_out_v;
    t_res                  r_out;

    assign en     = !r_out_v || i_pop;
    assign o_q_rd = en && i_q_valid;

    // per-frame divisors from the settings, registered ahead of the dividers
    assign sx = (i_cfg.first_x > i_cfg.second_x) ? i_cfg.first_x - i_cfg.second_x
                                                 : i_cfg.second_x - i_cfg.first_x;
    assign sy = (i_cfg.first_y > i_cfg.second_y) ? i_cfg.first_y - i_cfg.second_y
                                                 : i_cfg.second_y - i_cfg.first_y;
    assign w  = (32'(i_cfg.image_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : i_cfg.image_width;
    assign h  = (32'(i_cfg.image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : i_cfg.image_height;

    always_ff @(posedge i_clk) begin
        r_sx2 <= DEN_W'(sx) * DEN_W'(sx);
        r_sy2 <= DEN_W'(sy) * DEN_W'(sy);
        r_w2  <= DEN_W'(w) * DEN_W'(w);
        r_h2  <= DEN_W'(h) * DEN_W'(h);
    end

    // stage 1: queue head plus saturation flags (quotient would reach 2^24)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1            <= i_q_item;
            r_b1_sd.ch0     <= i_q_item.ch0;
            r_b1_sd.ch1     <= i_q_item.ch1;
            r_b1_sd.ch2     <= i_q_item.ch2;
            r_b1_sd.zspan   <= i_q_item.zspan;
            r_b1_sd.sat_dx  <= {8'd0, i_q_item.x2} >= {r_sx2, 8'd0};
            r_b1_sd.sat_dy  <= {8'd0, i_q_item.y2} >= {r_sy2, 8'd0};
            r_b1_sd.sat_ex  <= {8'd0, i_q_item.x2} >= {r_w2, 8'd0};
            r_b1_sd.sat_ey  <= {8'd0, i_q_item.y2} >= {r_h2, 8'd0};
        end
    end

    emb_div_pipe #(.NW(SQ_W + 16), .DW(DEN_W), .QB(RATIO_QB)) u_div_dx (
        .i_clk (i_clk), .i_en (en), .i_num ({r_b1.x2, 16'd0}), .i_den (r_sx2), .o_quo (q_dx)
    );
    emb_div_pipe #(.NW(SQ_W + 16), .DW(DEN_W), .QB(RATIO_QB)) u_div_dy (
        .i_clk (i_clk), .i_en (en), .i_num ({r_b1.y2, 16'd0}), .i_den (r_sy2), .o_quo (q_dy)
    );
    emb_div_pipe #(.NW(SQ_W + 16), .DW(DEN_W), .QB(RATIO_QB)) u_div_ex (
        .i_clk (i_clk), .i_en (en), .i_num ({r_b1.x2, 16'd0}), .i_den (r_w2), .o_quo (q_ex)
    );
    emb_div_pipe #(.NW(SQ_W + 16), .DW(DEN_W), .QB(RATIO_QB)) u_div_ey (
        .i_clk (i_clk), .i_en (en), .i_num ({r_b1.y2, 16'd0}), .i_den (r_h2), .o_quo (q_ey)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa[0] <= r_b1_sd;
            for (int k = 1; k < RATIO_QB; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
        end
    end

    assign rdx  = r_sa[RATIO_QB-1].sat_dx ? Q_MAX : q_dx;
    assign rdy  = r_sa[RATIO_QB-1].sat_dy ? Q_MAX : q_dy;
    assign rex  = r_sa[RATIO_QB-1].sat_ex ? Q_MAX : q_ex;
    assign rey  = r_sa[RATIO_QB-1].sat_ey ? Q_MAX : q_ey;
    assign dsum = {1'b0, rdx} + {1'b0, rdy};
    assign esum = {1'b0, rex} + {1'b0, rey};
    assign dval = dsum[Q_W] ? Q_MAX : dsum[Q_W-1:0];
    assign eval = esum[Q_W] ? Q_MAX : esum[Q_W-1:0];

    // stage: saturated sums and the inside test
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2.ch0     <= r_sa[RATIO_QB-1].ch0;
            r_b2.ch1     <= r_sa[RATIO_QB-1].ch1;
            r_b2.ch2     <= r_sa[RATIO_QB-1].ch2;
            r_b2.outside <= !r_sa[RATIO_QB-1].zspan && (dval > Q_ONE);
            r_b2.d       <= dval;
            r_b2.e       <= eval;
        end
    end

    // stage: falloff product
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b3.ch0     <= r_b2.ch0;
            r_b3.ch1     <= r_b2.ch1;
            r_b3.ch2     <= r_b2.ch2;
            r_b3.outside <= r_b2.outside;
            r_b3.p       <= P_W'(r_b2.d) * P_W'(r_b2.e);
        end
    end

    emb_div_pipe #(.NW(2*P_W + 1 - P_W), .DW(P_W), .QB(ALPHA_QB)) u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NUM_ONE[P_W:0]),
        .i_den (r_b3.p),
        .o_quo (q_a)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0].ch0     <= r_b3.ch0;
            r_sb[0].ch1     <= r_b3.ch1;
            r_sb[0].ch2     <= r_b3.ch2;
            r_sb[0].outside <= r_b3.outside;
            r_sb[0].bypass  <= (r_b3.p <= P_BYPASS);
            for (int k = 1; k < ALPHA_QB; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    assign last_a = r_sb[ALPHA_QB-1];
    assign alpha  = last_a.bypass ? A_ONE : {1'b0, q_a};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.outside <= last_a.outside;
            if (last_a.outside) begin
                r_out.ch0 <= blend(alpha, last_a.ch0);
                r_out.ch1 <= blend(alpha, last_a.ch1);
                r_out.ch2 <= blend(alpha, last_a.ch2);
            end else begin
                r_out.ch0 <= last_a.ch0;
                r_out.ch1 <= last_a.ch1;
                r_out.ch2 <= last_a.ch2;
            end
        end
    end

    // valid bits of every stage, all moving on the common enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_va    <= '0;
            r_b2_v  <= 1'b0;
            r_b3_v  <= 1'b0;
            r_vb    <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_b1_v  <= i_q_valid;
            r_va    <= {r_va[RATIO_QB-2:0], r_b1_v};
            r_b2_v  <= r_va[RATIO_QB-1];
            r_b3_v  <= r_b2_v;
            r_vb    <= {r_vb[ALPHA_QB-2:0], r_b3_v};
            r_out_v <= r_vb[ALPHA_QB-1];
        end
    end

    assign o_empty   = !r_out_v;
    assign o_ch0     = r_out.ch0;
    assign o_ch1     = r_out.ch1;
    assign o_ch2     = r_out.ch2;
    assign o_outside = r_out.outside;

    `EMB_ASSERT_IMP(a_outside_far, r_b2_v && r_b2.outside, r_b2.d > Q_ONE)
    `EMB_ASSERT_NXT(a_stall_keeps, !en && r_b2_v, r_b2_v)
    `EMB_ASSERT_NXT(a_inside_pass, en && r_vb[ALPHA_QB-1] && !last_a.outside, r_out.ch0 == $past(last_a.ch0) && r_out.ch2 == $past(last_a.ch2))
    `EMB_ASSERT_NXT(a_full_alpha_pass, en && r_vb[ALPHA_QB-1] && last_a.bypass, r_out.ch1 == $past(last_a.ch1))

endmodule

`default_nettype wire

FILE: rtl/elliptical_matte_blend_top.sv
// path: front reg, queue, stage 1, ratio dividers, sum, product, alpha divider, result
// throughput: one pixel per cycle unless stalled, by pipelined one-bit-per-stage dividers
// back end stalls as a whole only while a result waits unpopped; a 4-word queue decouples
// reset: synchronous active-low i_rst_n clears all valid state and loads register defaults
// top level: settings registers, front end, word queue, back end; uses emb_pkg
`default_nettype none

module elliptical_matte_blend_top
    import emb_pkg::*;
#(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // settings write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input side
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [COORD_W-1:0]    i_row,
    input  wire logic [COORD_W-1:0]    i_col,
    input  wire logic [CH_W-1:0]       i_in_ch0,
    input  wire logic [CH_W-1:0]       i_in_ch1,
    input  wire logic [CH_W-1:0]       i_in_ch2,
    // result side
    output logic                       empty,
    input  wire logic                  pop,
    output logic [CH_W-1:0]            o_out_ch0,
    output logic [CH_W-1:0]            o_out_ch1,
    output logic [CH_W-1:0]            o_out_ch2,
    output logic                       o_outside
);

    t_cfg    r_cfg;
    logic    f_valid;
    t_fitem  f_item;
    logic    q_full;
    logic    q_valid;
    t_fitem  q_item;
    logic    q_rd;

    // settings registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_x      <= '0;
            r_cfg.first_y      <= '0;
            r_cfg.second_x     <= '0;
            r_cfg.second_y     <= '0;
            r_cfg.image_width  <= DIM_W'(1);
            r_cfg.image_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_X: begin
                    r_cfg.first_x <= i_cfg_data[COORD_W-1:0];
                end
                CFG_FIRST_Y: begin
                    r_cfg.first_y <= i_cfg_data[COORD_W-1:0];
                end
                CFG_SECOND_X: begin
                    r_cfg.second_x <= i_cfg_data[COORD_W-1:0];
                end
                CFG_SECOND_Y: begin
                    r_cfg.second_y <= i_cfg_data[COORD_W-1:0];
                end
                CFG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // front end: takes a word, forms squared center offsets and the zero-span flag
    emb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_cfg    (r_cfg),
        .i_row    (i_row),
        .i_col    (i_col),
        .i_ch0    (i_in_ch0),
        .i_ch1    (i_in_ch1),
        .i_ch2    (i_in_ch2),
        .i_q_full (q_full),
        .o_valid  (f_valid),
        .o_item   (f_item)
    );

    // short queue so the front end keeps taking words while the back end is held
    emb_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back end: dividers, product, alpha, blend and the result register
    emb_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_ch0     (o_out_ch0),
        .o_ch1     (o_out_ch1),
        .o_ch2     (o_out_ch2),
        .o_outside (o_outside)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// testbench for elliptical_matte_blend_top: predicts each blended pixel and
// checks every popped word in order; depends on emb_pkg and the block's rtl
`default_nettype none

module tb;
    import emb_pkg::*;

    // register index past the end of the list, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CH_W-1:0]    c0;
        logic [CH_W-1:0]    c1;
        logic [CH_W-1:0]    c2;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_FIRST_X;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [COORD_W-1:0]    i_row = '0;
    logic [COORD_W-1:0]    i_col = '0;
    logic [CH_W-1:0]       i_in_ch0 = '0;
    logic [CH_W-1:0]       i_in_ch1 = '0;
    logic [CH_W-1:0]       i_in_ch2 = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [CH_W-1:0]       o_out_ch0;
    logic [CH_W-1:0]       o_out_ch1;
    logic [CH_W-1:0]       o_out_ch2;
    logic                  o_outside;

    // mirror of the settings registers
    logic [COORD_W-1:0] box_x1 = '0;
    logic [COORD_W-1:0] box_y1 = '0;
    logic [COORD_W-1:0] box_x2 = '0;
    logic [COORD_W-1:0] box_y2 = '0;
    logic [DIM_W-1:0]   img_w = 13'd1;
    logic [DIM_W-1:0]   img_h = 13'd1;

    t_pixel pixels_to_send[$];
    t_res   blended_due[$];
    t_pixel next_px;
    int     send_gap = 0;
    int     pop_stall = 0;
    bit     steady = 1'b0;
    int     errors = 0;

    elliptical_matte_blend_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_in_ch0   (i_in_ch0),
        .i_in_ch1   (i_in_ch1),
        .i_in_ch2   (i_in_ch2),
        .empty      (empty),
        .pop        (pop),
        .o_out_ch0  (o_out_ch0),
        .o_out_ch1  (o_out_ch1),
        .o_out_ch2  (o_out_ch2),
        .o_outside  (o_outside)
    );

    always #10 i_clk = ~i_clk;

    // squared distance between two coordinates
    function automatic longint unsigned sq_dist(longint unsigned a, longint unsigned b);
        longint unsigned m;
        m = (a > b) ? a - b : b - a;
        return m * m;
    endfunction

    // unsigned q8.16 quotient, saturating, zero divisor saturates
    function automatic longint unsigned q_ratio(longint unsigned num, longint unsigned den);
        longint unsigned q;
        if (den == 0) return Q_MAX;
        q = (num << 16) / den;
        return (q > Q_MAX) ? Q_MAX : q;
    endfunction

    function automatic longint unsigned q_add(longint unsigned a, longint unsigned b);
        return (a + b > Q_MAX) ? Q_MAX : a + b;
    endfunction

    function automatic logic [CH_W-1:0] mix_white(longint unsigned alpha, logic [CH_W-1:0] c);
        longint unsigned v;
        v = (alpha * c + (65536 - alpha) * 255 + 32768) >> 16;
        return (v > 255) ? WHITE : v[CH_W-1:0];
    endfunction

    // expected word for one pixel under the current register settings
    function automatic t_res blend_pixel(t_pixel px);
        t_res r;
        longint unsigned sx2, sy2, x2, y2, d, e, w, h, p, alpha;
        r.ch0 = px.c0;
        r.ch1 = px.c1;
        r.ch2 = px.c2;
        r.outside = 1'b0;
        sx2 = sq_dist(box_x1, box_x2);
        sy2 = sq_dist(box_y1, box_y2);
        if (sx2 == 0 || sy2 == 0) return r;
        x2 = sq_dist(2 * px.col, box_x1 + box_x2);
        y2 = sq_dist(2 * px.row, box_y1 + box_y2);
        d = q_add(q_ratio(x2, sx2), q_ratio(y2, sy2));
        if (d <= Q_ONE) return r;
        w = (img_w > MAX_DIM_DEF) ? MAX_DIM_DEF : img_w;
        h = (img_h > MAX_DIM_DEF) ? MAX_DIM_DEF : img_h;
        e = q_add(q_ratio(x2, w * w), q_ratio(y2, h * h));
        p = e * d;
        if (p == 0) alpha = 65536;
        else begin
            alpha = (64'd1 << 48) / p;
            if (alpha > 65536) alpha = 65536;
        end
        r.ch0 = mix_white(alpha, px.c0);
        r.ch1 = mix_white(alpha, px.c1);
        r.ch2 = mix_white(alpha, px.c2);
        r.outside = 1'b1;
        return r;
    endfunction

    // driver: feeds pixels from the pending queue, holds while full
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                blended_due.push_back(blend_pixel('{i_row, i_col, i_in_ch0, i_in_ch1,
                                                    i_in_ch2}));
            if (push && full) begin
                // word not taken yet, keep it on the bus
            end else if (send_gap > 0) begin
                push <= 1'b0;
                send_gap--;
            end else if (!steady && pixels_to_send.size() > 0
                         && $urandom_range(0, 15) == 0) begin
                send_gap = $urandom_range(1, 12) - 1;
                push <= 1'b0;
            end else if (pixels_to_send.size() > 0) begin
                next_px = pixels_to_send.pop_front();
                push     <= 1'b1;
                i_row    <= next_px.row;
                i_col    <= next_px.col;
                i_in_ch0 <= next_px.c0;
                i_in_ch1 <= next_px.c1;
                i_in_ch2 <= next_px.c2;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: random pop stalls, compares each popped word with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (blended_due.size() == 0) begin
                    $display("%0t: word with nothing expected: ch %0d %0d %0d outside %0b",
                             $time, o_out_ch0, o_out_ch1, o_out_ch2, o_outside);
                    errors++;
                end else begin
                    t_res want;
                    want = blended_due.pop_front();
                    if (o_out_ch0 !== want.ch0) begin
                        $display("%0t: ch0 expected %0d actual %0d", $time, want.ch0, o_out_ch0);
                        errors++;
                    end
                    if (o_out_ch1 !== want.ch1) begin
                        $display("%0t: ch1 expected %0d actual %0d", $time, want.ch1, o_out_ch1);
                        errors++;
                    end
                    if (o_out_ch2 !== want.ch2) begin
                        $display("%0t: ch2 expected %0d actual %0d", $time, want.ch2, o_out_ch2);
                        errors++;
                    end
                    if (o_outside !== want.outside) begin
                        $display("%0t: outside expected %0b actual %0b",
                                 $time, want.outside, o_outside);
                        errors++;
                    end
                end
            end
            if (pop_stall > 0) begin
                pop <= 1'b0;
                pop_stall--;
            end else if (!steady && $urandom_range(0, 15) == 0) begin
                pop_stall = $urandom_range(1, 12) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // register write, mirrored into the predictor settings
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_FIRST_X:      box_x1 = COORD_W'(val);
            CFG_FIRST_Y:      box_y1 = COORD_W'(val);
            CFG_SECOND_X:     box_x2 = COORD_W'(val);
            CFG_SECOND_Y:     box_y2 = COORD_W'(val);
            CFG_IMAGE_WIDTH:  img_w = DIM_W'(val);
            CFG_IMAGE_HEIGHT: img_h = DIM_W'(val);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_box(int x1, int y1, int x2, int y2, int w, int h);
        write_reg(CFG_FIRST_X, x1);
        write_reg(CFG_FIRST_Y, y1);
        write_reg(CFG_SECOND_X, x2);
        write_reg(CFG_SECOND_Y, y2);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic add_pixel(int row, int col, int c0, int c1, int c2);
        t_pixel px;
        px.row = COORD_W'(row);
        px.col = COORD_W'(col);
        px.c0  = CH_W'(c0);
        px.c1  = CH_W'(c1);
        px.c2  = CH_W'(c2);
        pixels_to_send.push_back(px);
    endtask

    // mostly pixels around the ellipse edge, the rest anywhere in the frame
    task automatic add_random_pixels(int n);
        int cx, cy, hx, hy, r, c;
        cx = (box_x1 + box_x2) / 2;
        cy = (box_y1 + box_y2) / 2;
        hx = ((box_x1 > box_x2) ? box_x1 - box_x2 : box_x2 - box_x1) / 2 + 2;
        hy = ((box_y1 > box_y2) ? box_y1 - box_y2 : box_y2 - box_y1) / 2 + 2;
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 4095);
                c = $urandom_range(0, 4095);
            end else begin
                r = cy + $signed($urandom_range(0, 6 * hy)) - 3 * hy;
                c = cx + $signed($urandom_range(0, 6 * hx)) - 3 * hx;
                r = (r < 0) ? 0 : (r > 4095) ? 4095 : r;
                c = (c < 0) ? 0 : (c > 4095) ? 4095 : c;
            end
            add_pixel(r, c, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        end
    endtask

    // hold the sender until the block has drained, then let trailing work settle
    task automatic wait_drained();
        while (pixels_to_send.size() > 0 || push || blended_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: zero span, every pixel passes through
        add_pixel(0, 0, 0, 0, 0);
        add_pixel(4095, 4095, 255, 255, 255);
        add_pixel(123, 2000, 170, 85, 1);
        wait_drained();

        // full frame box, corners and center
        set_box(0, 0, 4095, 4095, 4096, 4096);
        add_pixel(0, 0, 0, 255, 128);
        add_pixel(4095, 4095, 255, 0, 7);
        add_pixel(0, 4095, 255, 255, 255);
        add_pixel(4095, 0, 0, 0, 0);
        add_pixel(2047, 2048, 12, 200, 99);
        add_pixel(2047, 0, 90, 91, 92);
        add_pixel(0, 2047, 1, 254, 128);
        wait_drained();

        // tiny box, huge frame: near ones outside, zero product, unchanged; far one blends
        set_box(100, 100, 101, 101, 4096, 4096);
        add_pixel(100, 102, 10, 20, 30);
        add_pixel(101, 101, 40, 50, 60);
        add_pixel(0, 4095, 0, 128, 255);
        wait_drained();
        // zero span on one axis only
        write_reg(CFG_SECOND_Y, 100);
        add_pixel(0, 0, 77, 88, 99);
        wait_drained();

        // zero frame size saturates, oversize frame is clamped, index past list ignored
        set_box(4095, 4095, 0, 0, 0, 8191);
        write_reg(CFG_UNUSED, 13'h1FFF);
        add_pixel(0, 0, 33, 66, 99);
        add_pixel(2047, 2047, 33, 66, 99);
        add_pixel(4095, 1000, 200, 100, 0);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 8191);
        write_reg(CFG_IMAGE_HEIGHT, 1);
        add_pixel(10, 4000, 5, 250, 128);
        add_pixel(4095, 4095, 255, 255, 0);
        wait_drained();

        // random settings, mostly sane frame sizes; the last phase runs without idling
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) steady = 1'b1;
            set_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                : $urandom_range(1, 4096),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                : $urandom_range(1, 4096));
            if (ph == 3) set_box(1000, 800, 1200, 900, 64, 48);
            add_random_pixels(170);
            wait_drained();
        end

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: elliptical_matte_blend_top.f
+incdir+rtl
rtl/emb_pkg.sv
rtl/emb_div_pipe.sv
rtl/emb_front.sv
rtl/emb_queue.sv
rtl/emb_back.sv
rtl/elliptical_matte_blend_top.sv
verif/tb.sv
